### rtl/esw_pkg.sv
// ----------------------------------------------------------------------------
// esw_pkg
// Shared types and constants for the extrapolation slot and weight selector.
// ----------------------------------------------------------------------------
package esw_pkg;

  localparam int NUM_W  = 6;   // weight fields carried by one result
  localparam int W_BITS = 40;  // weight field width
  localparam int T_BITS = 32;  // time width

  localparam logic [1:0] ACT_FULL   = 2'd0;
  localparam logic [1:0] ACT_SAVE   = 2'd1;
  localparam logic [1:0] ACT_EXTRAP = 2'd2;

  typedef struct packed {
    logic [T_BITS-1:0] now_time;
    logic              update_required;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]        action;
    logic        [2:0]        slot;
    logic signed [W_BITS-1:0] weight_1;
    logic signed [W_BITS-1:0] weight_2;
    logic signed [W_BITS-1:0] weight_3;
    logic signed [W_BITS-1:0] weight_4;
    logic signed [W_BITS-1:0] weight_5;
    logic signed [W_BITS-1:0] weight_6;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_LOADI, S_FACT, S_MULN, S_MULD,
    S_DIVINIT, S_DIV, S_STORE, S_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_PLAIN, OP_SAVE, OP_TRIV, OP_EXTRAP, OP_LOADI,
    OP_FACT, OP_MULNUM, OP_MULDEN, OP_DIVINIT, OP_DIVSTEP, OP_STORE, OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    CLS_PLAIN, CLS_SAVE, CLS_TRIV, CLS_EXTRAP
  } cls_t;

  typedef struct packed {
    dp_op_t     op;
    logic       cfg_we;
    logic [2:0] idx_i;
    logic [2:0] idx_j;
    logic [5:0] bit_idx;
    logic       first;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] n;
    cls_t       kind;
    logic       out_free;
  } dp_sts_t;

endpackage

### rtl/esw_ctrl.sv
// ----------------------------------------------------------------------------
// esw_ctrl
// Sequencer: classifies a step, then walks weights, factors, multiply words
// and quotient bits.
// ----------------------------------------------------------------------------
module esw_ctrl
  import esw_pkg::*;
#(
  parameter int MAX_ORDER = 6
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] KLAST = 3'(MAX_ORDER - 2);
  localparam logic [5:0] BTOP  = 6'(W_BITS);

  ctl_state_t state_r, state_nxt;
  logic [2:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [5:0] bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        i_nxt = '0;
        if (sts.kind == CLS_EXTRAP) state_nxt = S_LOADI;
        else                        state_nxt = S_EMIT;
      end
      S_LOADI: begin
        j_nxt     = '0;
        state_nxt = S_FACT;
      end
      S_FACT: begin
        k_nxt = '0;
        priority if (j_r == sts.n) begin
          state_nxt = S_DIVINIT;
        end else if (j_r == i_r) begin
          j_nxt = j_r + 3'd1;
        end else begin
          state_nxt = S_MULN;
        end
      end
      S_MULN: begin
        if (k_r == KLAST) begin
          k_nxt     = '0;
          state_nxt = S_MULD;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_MULD: begin
        if (k_r == KLAST) begin
          k_nxt     = '0;
          j_nxt     = j_r + 3'd1;
          state_nxt = S_FACT;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_DIVINIT: begin
        bit_nxt   = BTOP;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (bit_r == '0) state_nxt = S_STORE;
        else             bit_nxt = bit_r - 6'd1;
      end
      S_STORE: begin
        if (i_r + 3'd1 == sts.n) begin
          state_nxt = S_EMIT;
        end else begin
          i_nxt     = i_r + 3'd1;
          state_nxt = S_LOADI;
        end
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.idx_i   = i_r;
    cmd.idx_j   = j_r;
    cmd.bit_idx = bit_r;
    cmd.first   = (k_r == '0);
    cmd.cfg_we  = cfg_valid && (state_r == S_IDLE);
    in_stall    = (state_r != S_IDLE);
    cfg_ready   = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE:    if (in_valid) cmd.op = OP_CAPTURE;
      S_CLASS: begin
        unique case (sts.kind)
          CLS_PLAIN: cmd.op = OP_PLAIN;
          CLS_SAVE:  cmd.op = OP_SAVE;
          CLS_TRIV:  cmd.op = OP_TRIV;
          default:   cmd.op = OP_EXTRAP;
        endcase
      end
      S_LOADI:   cmd.op = OP_LOADI;
      S_FACT:    if (j_r != sts.n && j_r != i_r) cmd.op = OP_FACT;
      S_MULN:    cmd.op = OP_MULNUM;
      S_MULD:    cmd.op = OP_MULDEN;
      S_DIVINIT: cmd.op = OP_DIVINIT;
      S_DIV:     cmd.op = OP_DIVSTEP;
      S_STORE:   cmd.op = OP_STORE;
      S_EMIT:    if (sts.out_free) cmd.op = OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/esw_dp.sv
// ----------------------------------------------------------------------------
// esw_dp
// Datapath: saved times, slot choice, word-serial products, restoring
// divider with rounding and saturation, result register.
// ----------------------------------------------------------------------------
module esw_dp
  import esw_pkg::*;
#(
  parameter int MAX_ORDER        = 6,
  parameter int WEIGHT_FRAC_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  logic [2:0] cfg_order,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int PWORDS = MAX_ORDER - 1;
  localparam int PW     = T_BITS * PWORDS;
  localparam int RW     = PW + WEIGHT_FRAC_BITS + 42;
  localparam logic [W_BITS-1:0] POS_MAX = {1'b0, {(W_BITS-1){1'b1}}};
  localparam logic [W_BITS-1:0] NEG_MIN = {1'b1, {(W_BITS-1){1'b0}}};
  localparam logic [W_BITS-1:0] ONE_W   = W_BITS'(1) << WEIGHT_FRAC_BITS;

  logic [2:0]        order_r, cnt_r, n;
  logic [T_BITS-1:0] now_r, ti_r, ma_r, mb_r, carry_r;
  logic              upd_r, neg_r, big_r, out_valid_r;
  logic [T_BITS-1:0] times_r [MAX_ORDER];
  logic [PW-1:0]     num_r, den_r;
  logic [RW-1:0]     rem_r, div_r;
  logic [W_BITS-1:0] q_r;
  logic [1:0]        act_r;
  logic [2:0]        slot_r;
  logic [W_BITS-1:0] w_r [NUM_W];
  out_item_t         out_r;

  // slot choice and coincidence over fixed taps
  logic [NUM_W-2:0] gt, up;
  logic             inc, found, coincide;
  logic [2:0]       first_dec, repl, slot_sel;

  always_comb begin
    n = (order_r > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : order_r;
    gt = '0;
    up = '0;
    for (int k = 0; k < MAX_ORDER - 1; k++) begin
      gt[k] = times_r[k] > times_r[k+1];
      up[k] = times_r[k+1] > times_r[k];
    end
    inc = 1'b1;
    for (int k = 0; k < MAX_ORDER - 1; k++) begin
      if (3'(k + 1) < n && !up[k]) inc = 1'b0;
    end
    found     = 1'b0;
    first_dec = n - 3'd1;
    for (int k = 0; k < MAX_ORDER - 2; k++) begin
      if (3'(k + 2) < n && !found && gt[k]) begin
        found     = 1'b1;
        first_dec = 3'(k + 1);
      end
    end
    priority if (n <= 3'd1) repl = 3'd0;
    else if (inc)           repl = 3'd0;
    else if (n == 3'd3)     repl = (up[1] && gt[0]) ? 3'd1 : 3'd2;
    else                    repl = first_dec;
    slot_sel = (cnt_r < n) ? cnt_r : repl;
    coincide = 1'b0;
    for (int a = 0; a < MAX_ORDER; a++) begin
      for (int b = a + 1; b < MAX_ORDER; b++) begin
        if (3'(b) < n && times_r[a] == times_r[b]) coincide = 1'b1;
      end
    end
  end

  always_comb begin
    sts.n        = n;
    sts.out_free = !out_valid_r || !out_stall;
    priority if (n == 3'd0 || (cnt_r < n && !upd_r)) sts.kind = CLS_PLAIN;
    else if (upd_r || cnt_r < n)                    sts.kind = CLS_SAVE;
    else if (n == 3'd1 || coincide)                 sts.kind = CLS_TRIV;
    else                                            sts.kind = CLS_EXTRAP;
  end

  // shared 32x32 multiplier, one word of the running product per cycle
  logic [T_BITS-1:0]   mul_w, mul_m, t_j;
  logic [2*T_BITS-1:0] mul_p;
  logic [PW-1:0]       prod_nxt;
  logic                rem_ge;
  logic [W_BITS-1:0]   w_nxt;

  always_comb begin
    mul_w    = (cmd.op == OP_MULDEN) ? den_r[T_BITS-1:0] : num_r[T_BITS-1:0];
    mul_m    = (cmd.op == OP_MULDEN) ? mb_r : ma_r;
    mul_p    = 64'(mul_w) * 64'(mul_m) + 64'(cmd.first ? '0 : carry_r);
    prod_nxt = PW'({mul_p[T_BITS-1:0], (cmd.op == OP_MULDEN) ? den_r : num_r} >> T_BITS);
    t_j      = times_r[cmd.idx_j[IW-1:0]];
    rem_ge   = rem_r >= div_r;
    if (!neg_r) w_nxt = (big_r || q_r[W_BITS-1]) ? POS_MAX : q_r;
    else        w_nxt = (big_r || q_r > NEG_MIN) ? NEG_MIN : W_BITS'(-q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.op == OP_EMIT)         out_valid_r <= 1'b1;
      if (cmd.cfg_we) begin
        order_r <= cfg_order;
        cnt_r   <= '0;
      end else if (cmd.op == OP_SAVE && cnt_r < n) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        now_r <= in_data.now_time;
        upd_r <= in_data.update_required;
      end
      OP_PLAIN: begin
        act_r  <= ACT_FULL;
        slot_r <= '0;
        for (int k = 0; k < NUM_W; k++) w_r[k] <= '0;
      end
      OP_SAVE: begin
        times_r[slot_sel[IW-1:0]] <= now_r;
        act_r  <= ACT_SAVE;
        slot_r <= slot_sel;
        for (int k = 0; k < NUM_W; k++) w_r[k] <= '0;
      end
      OP_TRIV: begin
        act_r  <= ACT_EXTRAP;
        slot_r <= '0;
        for (int k = 1; k < NUM_W; k++) w_r[k] <= '0;
        w_r[0] <= ONE_W;
      end
      OP_EXTRAP: begin
        act_r  <= ACT_EXTRAP;
        slot_r <= '0;
        for (int k = 0; k < NUM_W; k++) w_r[k] <= '0;
      end
      OP_LOADI: begin
        ti_r  <= times_r[cmd.idx_i[IW-1:0]];
        num_r <= PW'(1);
        den_r <= PW'(1);
        neg_r <= 1'b0;
      end
      OP_FACT: begin
        ma_r  <= (now_r >= t_j) ? now_r - t_j : t_j - now_r;
        mb_r  <= (ti_r >= t_j) ? ti_r - t_j : t_j - ti_r;
        neg_r <= neg_r ^ (now_r < t_j) ^ (ti_r < t_j);
      end
      OP_MULNUM: begin
        num_r   <= prod_nxt;
        carry_r <= mul_p[2*T_BITS-1:T_BITS];
      end
      OP_MULDEN: begin
        den_r   <= prod_nxt;
        carry_r <= mul_p[2*T_BITS-1:T_BITS];
      end
      OP_DIVINIT: begin
        // round half away: floor((num * 2^(F+1) + den) / (2 * den))
        rem_r <= (RW'(num_r) << (WEIGHT_FRAC_BITS + 1)) + RW'(den_r);
        div_r <= RW'(den_r) << (W_BITS + 1);
        q_r   <= '0;
        big_r <= 1'b0;
      end
      OP_DIVSTEP: begin
        if (rem_ge) begin
          rem_r <= rem_r - div_r;
          if (cmd.bit_idx == 6'(W_BITS)) big_r <= 1'b1;
          else                           q_r[cmd.bit_idx] <= 1'b1;
        end
        div_r <= div_r >> 1;
      end
      OP_STORE: w_r[cmd.idx_i] <= w_nxt;
      OP_EMIT: begin
        out_r.action   <= act_r;
        out_r.slot     <= slot_r;
        out_r.weight_1 <= w_r[0];
        out_r.weight_2 <= w_r[1];
        out_r.weight_3 <= w_r[2];
        out_r.weight_4 <= w_r[3];
        out_r.weight_5 <= w_r[4];
        out_r.weight_6 <= w_r[5];
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/extrapolation_slot_and_weights.sv
// ----------------------------------------------------------------------------
// extrapolation_slot_and_weights
// Per solver step: full evaluation, evaluate-and-save slot, or Lagrange
// extrapolation weights in signed fixed point with saturation.
// ----------------------------------------------------------------------------
// Plain and save steps pass from acceptance through classification to the
// emit state; the next transaction is accepted once the sequencer is idle.
// Extrapolation computes the n weights in turn (n = effective order), each
// with a word-serial 32x32 multiplier and a 41-step restoring divider.
// One transaction is in flight at a time; a stalled output holds the
// sequencer in its emit state.
// Reset (rst_n, synchronous): order 0, saved count 0, output empty.
// Saved times are undefined until written.
module extrapolation_slot_and_weights
  import esw_pkg::*;
#(
  parameter int MAX_ORDER        = 6,
  parameter int WEIGHT_FRAC_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_order
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  esw_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath holds the saved times, products, divider and result register
  esw_dp #(
    .MAX_ORDER        (MAX_ORDER),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_order (cfg_order),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one transaction at a time: an accept is followed by a busy cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on back-to-back cycles");

  // saved slot stays below MAX_ORDER
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == ACT_SAVE |-> out_data.slot < 3'(MAX_ORDER))
    else $error("save slot out of range");

  // non-extrapolation results carry zero weight_1 and weight_2, and action code 3 never appears
  a_weights_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != ACT_EXTRAP |->
      out_data.weight_1 == '0 && out_data.weight_2 == '0 &&
      out_data.action != 2'd3)
    else $error("weights present without extrapolation");

  // non-save results report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != ACT_SAVE |-> out_data.slot == '0)
    else $error("slot set on a non-save result");

endmodule

### tb/esw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esw_checker
// Watches the config, input and result channels of the extrapolation slot
// and weight selector, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module esw_checker
  import esw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [2:0] cfg_order,
  output int         err_count,
  output int         pending
);

  localparam int FRAC = 24;
  localparam int QD   = 8;   // expected-result ring depth
  localparam logic [255:0] POS_MAX = (256'd1 << (W_BITS - 1)) - 1;
  localparam logic [255:0] NEG_MAG = 256'd1 << (W_BITS - 1);

  logic [2:0]        order_q;
  int                saved_n;
  logic [T_BITS-1:0] times_q [6];
  out_item_t         exp_ring [QD];
  logic [2:0]        wr_ptr, rd_ptr;
  int                fill;

  initial err_count = 0;
  assign pending = fill;

  function automatic int eff_order();
    return (order_q > 3'd6) ? 6 : int'(order_q);
  endfunction

  function automatic int pick_slot(int n);
    bit inc;
    inc = 1;
    if (n <= 1) return 0;
    for (int k = 0; k + 1 < n; k++)
      if (!(times_q[k+1] > times_q[k])) inc = 0;
    if (inc) return 0;
    if (n == 3) begin
      if (times_q[2] > times_q[1] && times_q[0] > times_q[1]) return 1;
      return 2;
    end
    for (int k = 0; k + 2 < n; k++)
      if (times_q[k] > times_q[k+1]) return k + 1;
    return n - 1;
  endfunction

  // exact product ratio, rounded half away from zero, saturated to 40 bits
  function automatic logic [W_BITS-1:0] lagrange_wt(int n, int i, logic [31:0] now);
    logic [255:0] num, den, q;
    bit neg;
    num = 1;
    den = 1;
    neg = 0;
    for (int j = 0; j < n; j++) begin
      if (j == i) continue;
      if (now >= times_q[j]) num = num * {224'd0, now - times_q[j]};
      else begin
        neg = !neg;
        num = num * {224'd0, times_q[j] - now};
      end
      if (times_q[i] >= times_q[j]) den = den * {224'd0, times_q[i] - times_q[j]};
      else begin
        neg = !neg;
        den = den * {224'd0, times_q[j] - times_q[i]};
      end
    end
    q = ((num << (FRAC + 1)) + den) / (den << 1);
    if (!neg) return (q > POS_MAX) ? POS_MAX[W_BITS-1:0] : q[W_BITS-1:0];
    if (q > NEG_MAG) q = NEG_MAG;
    return -q[W_BITS-1:0];
  endfunction

  function automatic out_item_t predict_step(in_item_t it);
    out_item_t r;
    logic [W_BITS-1:0] w [6];
    int n, s;
    bit same;
    r = '0;
    n = eff_order();
    for (int k = 0; k < 6; k++) w[k] = '0;
    if (n == 0 || (saved_n < n && !it.update_required)) begin
      r.action = ACT_FULL;
      return r;
    end
    if (it.update_required || saved_n < n) begin
      if (saved_n < n) begin
        s = saved_n;
        saved_n++;
      end else begin
        s = pick_slot(n);
      end
      times_q[s] = it.now_time;
      r.action = ACT_SAVE;
      r.slot = 3'(s);
      return r;
    end
    r.action = ACT_EXTRAP;
    same = 0;
    for (int a = 0; a < n; a++)
      for (int b = a + 1; b < n; b++)
        if (times_q[a] == times_q[b]) same = 1;
    if (n == 1 || same) w[0] = W_BITS'(1) << FRAC;
    else for (int k = 0; k < n; k++) w[k] = lagrange_wt(n, k, it.now_time);
    r.weight_1 = w[0];
    r.weight_2 = w[1];
    r.weight_3 = w[2];
    r.weight_4 = w[3];
    r.weight_5 = w[4];
    r.weight_6 = w[5];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      order_q = 3'd0;
      saved_n = 0;
      wr_ptr  = '0;
      rd_ptr  = '0;
      fill    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        order_q = cfg_order;
        saved_n = 0;
      end
      if (in_valid && !in_stall) begin
        exp_ring[wr_ptr] = predict_step(in_data);
        wr_ptr = wr_ptr + 3'd1;
        fill++;
      end
      if (out_valid && !out_stall) begin
        if (fill == 0) report("unexpected transaction", '0, '0);
        else begin
          e = exp_ring[rd_ptr];
          rd_ptr = rd_ptr + 3'd1;
          fill--;
          if (out_data.action !== e.action) report("action", out_data.action, e.action);
          if (out_data.slot !== e.slot) report("slot", out_data.slot, e.slot);
          if (out_data.weight_1 !== e.weight_1) report("weight_1", out_data.weight_1, e.weight_1);
          if (out_data.weight_2 !== e.weight_2) report("weight_2", out_data.weight_2, e.weight_2);
          if (out_data.weight_3 !== e.weight_3) report("weight_3", out_data.weight_3, e.weight_3);
          if (out_data.weight_4 !== e.weight_4) report("weight_4", out_data.weight_4, e.weight_4);
          if (out_data.weight_5 !== e.weight_5) report("weight_5", out_data.weight_5, e.weight_5);
          if (out_data.weight_6 !== e.weight_6) report("weight_6", out_data.weight_6, e.weight_6);
        end
      end
    end
  end

endmodule

### tb/tb_extrapolation_slot_and_weights.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_extrapolation_slot_and_weights
// Drives solver steps through the selector across all order settings, with
// random idle and stall, a long output hold-off and a drain pause; the
// checker predicts every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_extrapolation_slot_and_weights;
  import esw_pkg::*;

  localparam int LIMIT = 6000000;   // cycles; far above slowest legal run

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_order;
  int         err_count;
  int         pending;

  int          cycles;
  bit          quiet;      // no idling on either side while set
  bit          hold_req;   // ask the receiver for one long hold-off
  logic [31:0] t_base;     // running solver time
  logic [31:0] t_last;

  initial clk = 0;
  always #5 clk = ~clk;

  extrapolation_slot_and_weights DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_order(cfg_order)
  );

  esw_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_order(cfg_order),
    .err_count(err_count), .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_extrapolation_slot_and_weights: errors");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1;
        repeat (300) @(negedge clk);
        out_stall <= 0;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 21);
      end
    end
  end

  // one input transaction; called and returns at a falling edge
  task automatic send_item(logic [31:0] t, logic upd);
    if (!quiet && $urandom_range(0, 99) < 21) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1;
    in_data.now_time <= t;
    in_data.update_required <= upd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    t_last = t;
  endtask

  // order writes happen only with nothing outstanding and the block settled
  task automatic write_order(logic [2:0] v);
    in_valid <= 0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    cfg_valid <= 1;
    cfg_order <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // mostly rising solver times; some wild, repeated and backward steps
  task automatic random_step();
    int r;
    logic [31:0] t;
    r = $urandom_range(0, 99);
    if (r < 8) t = $urandom;
    else if (r < 14) t = t_last;
    else if (r < 20) t = t_base - $urandom_range(1, 3000);
    else begin
      t_base = t_base + $urandom_range(1, 5000);
      t = t_base;
    end
    send_item(t, $urandom_range(0, 99) < 35);
  endtask

  initial begin
    logic [2:0] order_seq [14];
    int per_phase;
    order_seq = '{3'd0, 3'd1, 3'd2, 3'd7, 3'd6, 3'd4, 3'd5, 3'd3,
                  3'd2, 3'd1, 3'd6, 3'd3, 3'd0, 3'd4};
    cycles = 0;
    quiet = 0;
    hold_req = 0;
    t_base = 32'h1000_0000;
    t_last = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_order = 3'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset order gives plain steps, then order 3 through
    // filling, extrapolation, saturation, replacement and coinciding times
    send_item(32'h0, 1'b1);
    write_order(3'd3);
    send_item(32'd5, 1'b0);
    send_item(32'd100, 1'b1);
    send_item(32'd200, 1'b1);
    send_item(32'd300, 1'b1);
    send_item(32'd400, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0, 1'b0);
    send_item(32'd50, 1'b1);
    send_item(32'd350, 1'b0);
    send_item(32'd300, 1'b1);
    send_item(32'd300, 1'b1);
    send_item(32'd500, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b1);
    send_item(32'h5555_5555, 1'b1);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_0001, 1'b1);
    send_item(32'h1234_5678, 1'b0);

    // random phases across order settings
    for (int p = 0; p < 14; p++) begin
      write_order(order_seq[p]);
      per_phase = (order_seq[p] >= 3'd5) ? 90 : 130;
      for (int k = 0; k < per_phase; k++) begin
        quiet = (p == 2);
        if (p == 5 && k == 20) hold_req = 1;   // block backs up behind output
        if (p == 8 && k == 40) begin           // drain before going on
          in_valid <= 0;
          wait (pending == 0);
          @(negedge clk);
        end
        random_step();
      end
    end
    quiet = 0;
    in_valid <= 0;

    wait (pending == 0);
    repeat (2000) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_extrapolation_slot_and_weights: clean");
    end else begin
      $display("tb_extrapolation_slot_and_weights: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/esw_pkg.sv
rtl/esw_ctrl.sv
rtl/esw_dp.sv
rtl/extrapolation_slot_and_weights.sv
tb/esw_checker.sv
tb/tb_extrapolation_slot_and_weights.sv
